[hw/rtl/mhcp_pkg.sv]
// shared types and constants for the mach-o header and load command parser
package mhcp_pkg;

  localparam int POSITION_BITS = 32;
  localparam int CMP_BITS      = (POSITION_BITS > 33) ? POSITION_BITS : 33;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MAGIC_64       = 32'hfeedfacf;
  localparam logic [31:0] CODE_BUILD     = 32'h00000032;
  localparam logic [31:0] CODE_MIN_MAC   = 32'h00000024;
  localparam logic [31:0] CODE_MIN_IOS   = 32'h00000025;
  localparam logic [31:0] CODE_MIN_TV    = 32'h0000002f;
  localparam logic [31:0] CODE_MIN_WATCH = 32'h00000030;
  localparam logic [32:0] HEADER_BYTES   = 33'd32;

  localparam logic [4:0] HDR_MAGIC_END  = 5'd3;
  localparam logic [4:0] HDR_CPU_END    = 5'd7;
  localparam logic [4:0] HDR_TYPE_END   = 5'd15;
  localparam logic [4:0] HDR_NCMDS_END  = 5'd19;
  localparam logic [4:0] HDR_SIZE_END   = 5'd23;
  localparam logic [4:0] HDR_LAST       = 5'd31;

  localparam logic [31:0] CMD_CODE_END  = 32'd3;
  localparam logic [31:0] CMD_LEN_END   = 32'd7;
  localparam logic [31:0] CMD_VMIN_END  = 32'd11;
  localparam logic [31:0] CMD_BUILD_END = 32'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        slice_ok;
    logic [31:0] cpu_type;
    logic [31:0] file_type;
    logic [31:0] min_os_version;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     last_byte;
    logic                     in_header;
    logic [4:0]               header_index;
    logic [POSITION_BITS-1:0] position_after;
  } tagged_beat_t;

endpackage

[hw/rtl/mhcp_front.sv]
// front end: byte position counter and header tagging of incoming beats
module mhcp_front
  import mhcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_beat_t     in_data,
  output logic         push,
  output tagged_beat_t push_data,
  input  logic         queue_full
);

  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] position_sat;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign position_sat = (position == {POSITION_BITS{1'b1}}) ? position
                        : position + {{(POSITION_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    push_data.data_byte      = in_data.data_byte;
    push_data.last_byte      = in_data.last_byte;
    push_data.in_header      = (position[POSITION_BITS-1:5] == '0);
    push_data.header_index   = position[4:0];
    push_data.position_after = position_sat;
  end

  always_comb begin
    position_next = position;
    if (push) begin
      position_next = in_data.last_byte ? '0 : position_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

endmodule

[hw/rtl/mhcp_queue.sv]
// short fifo of tagged beats between front and back
module mhcp_queue
  import mhcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tagged_beat_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output tagged_beat_t head_data
);

  tagged_beat_t          entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic [QCNT_BITS-1:0]  count_next;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/mhcp_back.sv]
// back end: header checks, load command walk and result register
module mhcp_back
  import mhcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  tagged_beat_t head_data,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output out_beat_t    out_data
);

  logic [31:0] word_assembly, word_assembly_next;
  logic [31:0] cpu_word, cpu_word_next;
  logic [31:0] type_word, type_word_next;
  logic [31:0] commands_left, commands_left_next;
  logic [31:0] command_region_size, command_region_size_next;
  logic [31:0] command_offset, command_offset_next;
  logic [31:0] command_code, command_code_next;
  logic [31:0] command_length, command_length_next;
  logic [31:0] version_word, version_word_next;
  logic [31:0] in_command, in_command_next;
  logic        build_seen, build_seen_next;
  logic        failed, failed_next;
  logic        out_valid_next;
  out_beat_t   out_data_next;

  logic [31:0]         k_inc;
  logic [31:0]         length_eff;
  logic [31:0]         offset_sum;
  logic [31:0]         left_dec;
  logic                vmin_code;
  logic [CMP_BITS-1:0] pos_ext;
  logic [CMP_BITS-1:0] need_ext;
  logic                ok;

  assign pop = head_valid && (!head_data.last_byte || !out_valid || out_ready);

  assign vmin_code = (command_code == CODE_MIN_MAC) || (command_code == CODE_MIN_IOS) ||
                     (command_code == CODE_MIN_TV) || (command_code == CODE_MIN_WATCH);

  assign k_inc      = in_command + 32'd1;
  assign length_eff = (in_command == CMD_LEN_END) ? word_assembly_next : command_length;
  assign offset_sum = command_offset + length_eff;
  assign left_dec   = commands_left - 32'd1;

  always_comb begin
    word_assembly_next       = word_assembly;
    cpu_word_next            = cpu_word;
    type_word_next           = type_word;
    commands_left_next       = commands_left;
    command_region_size_next = command_region_size;
    command_offset_next      = command_offset;
    command_code_next        = command_code;
    command_length_next      = command_length;
    version_word_next        = version_word;
    in_command_next          = in_command;
    build_seen_next          = build_seen;
    failed_next              = failed;

    if (pop) begin
      word_assembly_next = {head_data.data_byte, word_assembly[31:8]};
      if (!failed) begin
        if (head_data.in_header) begin
          case (head_data.header_index)
            HDR_MAGIC_END: begin
              if (word_assembly_next != MAGIC_64) begin
                failed_next = 1'b1;
              end
            end
            HDR_CPU_END:   cpu_word_next = word_assembly_next;
            HDR_TYPE_END:  type_word_next = word_assembly_next;
            HDR_NCMDS_END: commands_left_next = word_assembly_next;
            HDR_SIZE_END:  command_region_size_next = word_assembly_next;
            HDR_LAST: begin
              command_offset_next = '0;
              in_command_next     = '0;
              if (commands_left != '0 && command_region_size < 32'd8) begin
                failed_next = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (commands_left != '0) begin
          if (in_command == CMD_CODE_END) begin
            command_code_next = word_assembly_next;
          end
          if (in_command == CMD_LEN_END) begin
            command_length_next = word_assembly_next;
          end
          if (in_command == CMD_LEN_END && (word_assembly_next < 32'd8 ||
              word_assembly_next > command_region_size - command_offset)) begin
            failed_next = 1'b1;
          end else begin
            if (in_command == CMD_VMIN_END && !build_seen &&
                command_length >= 32'd12 && vmin_code) begin
              version_word_next = word_assembly_next;
            end
            if (in_command == CMD_BUILD_END && command_code == CODE_BUILD &&
                command_length >= 32'd16) begin
              version_word_next = word_assembly_next;
              build_seen_next   = 1'b1;
            end
            if (k_inc >= 32'd8 && k_inc == length_eff) begin
              command_offset_next = offset_sum;
              commands_left_next  = left_dec;
              in_command_next     = '0;
              if (left_dec != '0 &&
                  ({1'b0, offset_sum} + 33'd8) > {1'b0, command_region_size}) begin
                failed_next = 1'b1;
              end
            end else begin
              in_command_next = k_inc;
            end
          end
        end
      end
    end
  end

  assign pos_ext  = CMP_BITS'(head_data.position_after);
  assign need_ext = CMP_BITS'(HEADER_BYTES + {1'b0, command_region_size_next});
  assign ok = !failed_next && (pos_ext >= CMP_BITS'(HEADER_BYTES)) &&
              (pos_ext >= need_ext) && (commands_left_next == '0);

  always_comb begin
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (pop && head_data.last_byte) begin
      out_valid_next               = 1'b1;
      out_data_next.slice_ok       = ok;
      out_data_next.cpu_type       = ok ? cpu_word_next : '0;
      out_data_next.file_type      = ok ? type_word_next : '0;
      out_data_next.min_os_version = ok ? version_word_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head_data.last_byte)) begin
      word_assembly       <= '0;
      cpu_word            <= '0;
      type_word           <= '0;
      commands_left       <= '0;
      command_region_size <= '0;
      command_offset      <= '0;
      command_code        <= '0;
      command_length      <= '0;
      version_word        <= '0;
      in_command          <= '0;
      build_seen          <= 1'b0;
      failed              <= 1'b0;
    end else begin
      word_assembly       <= word_assembly_next;
      cpu_word            <= cpu_word_next;
      type_word           <= type_word_next;
      commands_left       <= commands_left_next;
      command_region_size <= command_region_size_next;
      command_offset      <= command_offset_next;
      command_code        <= command_code_next;
      command_length      <= command_length_next;
      version_word        <= version_word_next;
      in_command          <= in_command_next;
      build_seen          <= build_seen_next;
      failed              <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/macho_header_command_parser.sv]
// top level of the streaming 64-bit mach-o header and load command parser
//
// input channel: one image byte per beat (data_byte) with last_byte set on
// the final byte of the image. output channel: one result beat per image,
// produced when the beat carrying last_byte has been processed.
// throughput: one input beat per cycle, sustained, as long as results are
// taken; the byte position counter in the front end and the parse step in
// the back end each handle one byte per clock.
// result path: the last beat is written into the queue, popped from its head
// once no result is held or the held one is taken, and loads the result register.
// a two-entry queue separates front and back; while a result is held
// because out_ready is low, bytes of the next image keep flowing in until
// the next last beat reaches the head of the queue, then in_ready drops
// once the queue fills.
// reset clears the position counter, queue pointers, parse state and out_valid;
// the result data is not reset. all parse state also returns to zero
// after each image. failed images report slice_ok low with all other fields zero.
module macho_header_command_parser
  import mhcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic         push;
  tagged_beat_t push_data;
  logic         queue_full;
  logic         pop;
  logic         head_valid;
  tagged_beat_t head_data;

  mhcp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  mhcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  mhcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.slice_ok |->
      out_data.cpu_type == '0 && out_data.file_type == '0 &&
      out_data.min_os_version == '0)
    else $error("failed result carries nonzero fields");

  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> head_valid)
    else $error("input stalled with empty queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    pop && head_data.last_byte |=> out_valid)
    else $error("last beat popped without result");

endmodule
